// File: hw/rtl/erqd_pkg.sv
// shared types and constants of the event ring queue dispatcher
package erqd_pkg;

	// field widths of one queued record
	localparam int CODE_W  = 8;
	localparam int CTX_W   = 32;
	localparam int COUNT_W = 16;
	localparam int MASK_W  = 16;
	localparam int SLOT_W  = CODE_W + CTX_W;

	// item kinds
	localparam logic KIND_RAISE    = 1'b0;
	localparam logic KIND_DISPATCH = 1'b1;

	// route codes of a dispatched record
	localparam logic [1:0] ROUTE_HANDLER    = 2'd0;
	localparam logic [1:0] ROUTE_RANGE      = 2'd1;
	localparam logic [1:0] ROUTE_NO_HANDLER = 2'd2;

	// input beat
	typedef struct packed {
		logic               kind;
		logic [CODE_W-1:0]  event_code;
		logic [CTX_W-1:0]   event_context;
		logic [COUNT_W-1:0] dispatch_count;
	} item_t;

	// result beat
	typedef struct packed {
		logic              result_kind;
		logic              accepted;
		logic [CODE_W-1:0] out_code;
		logic [CTX_W-1:0]  out_context;
		logic [1:0]        route;
		logic              last;
	} result_t;

	// dispatch sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_DISP
	} state_t;

endpackage

// File: hw/rtl/event_ring_queue_dispatcher.sv
// top level: event ring queue with route classification of popped records
//
// Events are held in a ring of QUEUE_DEPTH slots (a power of two) in one
// synchronous ram; one slot stays empty, so QUEUE_DEPTH-1 records fit. A raise
// is taken in any cycle in which busy is low and its status beat appears on the
// result ports in the next cycle; raises can follow each other every cycle. A
// dispatch keeps busy high until its last slot read has left the ram, and
// delivers one record per cycle, oldest first, through the registered ram read
// and the output register; the next item can be taken in the cycle of the final
// record. The pace is set by the single read port of the slot ram. A dispatch
// with count zero or an empty queue gives no beat. Each result beat is shown
// for exactly one cycle with strobe high; the receiver must take it then, as it
// cannot stall. The handler mask is written through cfg_we and cfg_wdata; the
// user must write it only while the block is idle; the block does not enforce it.
// The slot ram has no clearing pass; only written slots are ever read.
module event_ring_queue_dispatcher
	import erqd_pkg::*;
#(
	parameter int QUEUE_DEPTH     = 32,
	parameter int NUM_EVENT_KINDS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  item_t             item,
	input  logic              cfg_we,
	input  logic [MASK_W-1:0] cfg_wdata,
	output logic              strobe,
	output result_t           result
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [CODE_W:0] NUM_KINDS = (CODE_W + 1)'(NUM_EVENT_KINDS);

	state_t             state_q, state_d;
	logic [PTR_W-1:0]   rd_ptr_q, wr_ptr_q;
	logic [PTR_W-1:0]   rd_next, wr_next;
	logic [COUNT_W-1:0] remain_q, remain_d;
	logic [MASK_W-1:0]  mask_q;
	logic               rd_valid_s1, last_s1;
	logic               accept, is_raise, full, empty;
	logic               issue, issue_last;
	logic               ram_we;
	logic [SLOT_W-1:0]  ram_wdata, ram_rdata;
	logic [CODE_W-1:0]  rd_code;
	logic [CTX_W-1:0]   rd_ctx;
	logic [1:0]         rd_route;
	logic               strobe_q;
	result_t            result_q;

	// handshake and ring status
	assign busy     = (state_q == ST_DISP) || rd_valid_s1;
	assign accept   = start && !busy;
	assign is_raise = item.kind == KIND_RAISE;
	assign wr_next  = wr_ptr_q + 1'b1;
	assign rd_next  = rd_ptr_q + 1'b1;
	assign full     = wr_next == rd_ptr_q;
	assign empty    = rd_ptr_q == wr_ptr_q;

	// slot write on an accepted raise
	assign ram_we    = accept && is_raise && !full;
	assign ram_wdata = {item.event_code, item.event_context};

	erqd_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_ptr_q),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	// dispatch sequencer: one slot read per cycle until count spent or ring empty
	always_comb begin
		state_d    = state_q;
		issue      = 1'b0;
		issue_last = 1'b0;
		remain_d   = remain_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !is_raise && (item.dispatch_count != '0) && !empty) begin
					issue      = 1'b1;
					issue_last = (item.dispatch_count == COUNT_W'(1)) || (rd_next == wr_ptr_q);
					remain_d   = item.dispatch_count - 1'b1;
					state_d    = issue_last ? ST_IDLE : ST_DISP;
				end
			end
			ST_DISP: begin
				issue      = 1'b1;
				issue_last = (remain_q == COUNT_W'(1)) || (rd_next == wr_ptr_q);
				remain_d   = remain_q - 1'b1;
				state_d    = issue_last ? ST_IDLE : ST_DISP;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			remain_q    <= '0;
			mask_q      <= '0;
			rd_valid_s1 <= 1'b0;
			last_s1     <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			state_q     <= state_d;
			remain_q    <= remain_d;
			rd_valid_s1 <= issue;
			last_s1     <= issue_last;
			strobe_q    <= (accept && is_raise) || rd_valid_s1;
			if (issue) begin
				rd_ptr_q <= rd_next;
			end
			if (ram_we) begin
				wr_ptr_q <= wr_next;
			end
			if (cfg_we) begin
				mask_q <= cfg_wdata;
			end
		end
	end

	// route of the record coming out of the ram
	assign rd_code = ram_rdata[SLOT_W-1:CTX_W];
	assign rd_ctx  = ram_rdata[CTX_W-1:0];

	always_comb begin
		if ({1'b0, rd_code} >= NUM_KINDS) begin
			rd_route = ROUTE_RANGE;
		end else if ((rd_code[CODE_W-1:4] == '0) && mask_q[rd_code[3:0]]) begin
			rd_route = ROUTE_HANDLER;
		end else begin
			rd_route = ROUTE_NO_HANDLER;
		end
	end

	// output register: raise status or popped record
	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			result_q.result_kind <= KIND_DISPATCH;
			result_q.accepted    <= 1'b0;
			result_q.out_code    <= rd_code;
			result_q.out_context <= rd_ctx;
			result_q.route       <= rd_route;
			result_q.last        <= last_s1;
		end else if (accept && is_raise) begin
			result_q.result_kind <= KIND_RAISE;
			result_q.accepted    <= !full;
			result_q.out_code    <= '0;
			result_q.out_context <= '0;
			result_q.route       <= ROUTE_HANDLER;
			result_q.last        <= 1'b1;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// File: hw/rtl/erqd_ram.sv
// generic single-write, single-read ram with registered read data
module erqd_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/erqd_checker.sv
// port-level checks of the event ring queue dispatcher and their bind
module erqd_checker
	import erqd_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input item_t             item,
	input logic              cfg_we,
	input logic [MASK_W-1:0] cfg_wdata,
	input logic              strobe,
	input result_t           result
);

	// a raise beat is always the final one of its item
	a_raise_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.result_kind == KIND_RAISE) |-> result.last)
		else $error("raise status beat without last");

	// an accepted raise reports in the next cycle
	a_raise_status: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.kind == KIND_RAISE) |=>
		strobe && (result.result_kind == KIND_RAISE))
		else $error("raise status beat missing");

	// popped records of one dispatch come back to back
	a_records_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.result_kind == KIND_DISPATCH) && !result.last |=>
		strobe && (result.result_kind == KIND_DISPATCH))
		else $error("gap inside a dispatch burst");

	// the block is free again with the final record
	a_free_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.result_kind == KIND_DISPATCH) && result.last |-> !busy)
		else $error("busy after the final record");

	// a dispatch of zero records gives no beat
	a_empty_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.kind == KIND_DISPATCH) && (item.dispatch_count == '0)
		|=> !strobe)
		else $error("beat from a dispatch of zero records");

endmodule

bind event_ring_queue_dispatcher erqd_checker u_erqd_checker (.*);

// File: tb/tb.sv
// testbench of the event ring queue dispatcher: table-driven and random raise/dispatch beats
module tb;
	import erqd_pkg::*;

	localparam int RING_SLOTS  = 32;
	localparam int EVENT_KINDS = 16;
	localparam int STALL_LIMIT = 400;
	localparam int RAND_ITEMS  = 66;
	localparam int DIR_ROWS    = 15;

	// status beat of a raise that got into the ring
	localparam result_t RAISE_TAKEN = '{1'b0, 1'b1, 8'd0, 32'd0, ROUTE_HANDLER, 1'b1};
	// lone record popped by a dispatch of one, code zero, context zero, handler set
	localparam result_t POP_CODE0   = '{1'b1, 1'b0, 8'd0, 32'd0, ROUTE_HANDLER, 1'b1};

	// one row of the directed table; pinned rows carry their status beat typed in
	typedef struct {
		item_t   it;
		bit      pinned;
		result_t beat;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	item_t             item = '0;
	logic              cfg_we = 1'b0;
	logic [MASK_W-1:0] cfg_wdata = '0;
	logic              strobe;
	result_t           result;

	// typed-in beat riding along with the driven item
	logic    pin_valid = 1'b0;
	result_t pin_beat = '0;

	// shadow of the ring and the handler mask
	logic [CODE_W-1:0] ring_code [RING_SLOTS];
	logic [CTX_W-1:0]  ring_ctx [RING_SLOTS];
	logic [4:0]        rd_ptr = '0;
	logic [4:0]        wr_ptr = '0;
	logic [MASK_W-1:0] handlers = '0;

	result_t due_beats [$];
	int      errs = 0;
	int      quiet_cycles = 0;
	int      burst_left = 0;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{'{KIND_DISPATCH, 8'h00, 32'h0000_0000, 16'd5},      1'b0, '0},
		'{'{KIND_RAISE,    8'h00, 32'h0000_0000, 16'hFFFF},   1'b1, RAISE_TAKEN},
		'{'{KIND_DISPATCH, 8'hFF, 32'hFFFF_FFFF, 16'd0},      1'b0, '0},
		'{'{KIND_DISPATCH, 8'h00, 32'h0000_0000, 16'd1},      1'b1, POP_CODE0},
		'{'{KIND_RAISE,    8'hFF, 32'hFFFF_FFFF, 16'd0},      1'b1, RAISE_TAKEN},
		'{'{KIND_RAISE,    8'h0F, 32'h1234_5678, 16'h5555},   1'b1, RAISE_TAKEN},
		'{'{KIND_RAISE,    8'h05, 32'hDEAD_BEEF, 16'hAAAA},   1'b1, RAISE_TAKEN},
		'{'{KIND_RAISE,    8'h10, 32'h0000_0000, 16'd3},      1'b1, RAISE_TAKEN},
		'{'{KIND_DISPATCH, 8'h00, 32'h0000_0000, 16'hFFFF},   1'b0, '0},
		'{'{KIND_RAISE,    8'h80, 32'h8000_0000, 16'h8000},   1'b0, '0},
		'{'{KIND_RAISE,    8'h7F, 32'h7FFF_FFFF, 16'h7FFF},   1'b0, '0},
		'{'{KIND_RAISE,    8'h01, 32'h0000_0001, 16'd0},      1'b0, '0},
		'{'{KIND_DISPATCH, 8'h00, 32'h0000_0000, 16'd2},      1'b0, '0},
		'{'{KIND_DISPATCH, 8'h00, 32'h0000_0000, 16'h8000},   1'b0, '0},
		'{'{KIND_DISPATCH, 8'h00, 32'h0000_0000, 16'd1},      1'b0, '0}
	};

	event_ring_queue_dispatcher u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.strobe   (strobe),
		.result   (result)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	// shadow queue: push an accepted item, predict its beats
	task automatic queue_advance(item_t it);
		logic [4:0]         nxt;
		logic [COUNT_W-1:0] left;
		logic [CODE_W-1:0]  code;
		int                 popped;
		result_t            b;
		if (it.kind == KIND_RAISE) begin
			nxt = wr_ptr + 5'd1;
			b = RAISE_TAKEN;
			if (nxt != rd_ptr) begin
				ring_code[wr_ptr] = it.event_code;
				ring_ctx[wr_ptr] = it.event_context;
				wr_ptr = nxt;
			end else begin
				b.accepted = 1'b0;
			end
			due_beats.push_back(b);
		end else begin
			left = it.dispatch_count;
			popped = 0;
			while (left != 0 && rd_ptr != wr_ptr) begin
				code = ring_code[rd_ptr];
				b = '0;
				b.result_kind = KIND_DISPATCH;
				b.out_code = code;
				b.out_context = ring_ctx[rd_ptr];
				if (code >= EVENT_KINDS)
					b.route = ROUTE_RANGE;
				else if (code < MASK_W && handlers[code[3:0]])
					b.route = ROUTE_HANDLER;
				else
					b.route = ROUTE_NO_HANDLER;
				due_beats.push_back(b);
				rd_ptr = rd_ptr + 5'd1;
				left = left - 1'b1;
				popped++;
			end
			if (popped != 0)
				due_beats[$].last = 1'b1;
		end
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errs++;
		end
	endfunction

	// monitor: check result beats, then predict for the item taken at this edge
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (strobe) begin
				if (due_beats.size() == 0) begin
					$error("result beat with nothing expected: %h", result);
					errs++;
				end else begin
					want = due_beats.pop_front();
					check_field("result_kind", want.result_kind, result.result_kind);
					check_field("accepted", want.accepted, result.accepted);
					check_field("out_code", want.out_code, result.out_code);
					check_field("out_context", want.out_context, result.out_context);
					check_field("route", want.route, result.route);
					check_field("last", want.last, result.last);
				end
			end
			if (start && !busy) begin
				queue_advance(item);
				if (pin_valid)
					due_beats[$] = pin_beat;
			end
			if (cfg_we)
				handlers = cfg_wdata;
			if (strobe || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// watchdog
	initial begin
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	// hold one beat on the bus until it is taken
	task automatic send_beat(item_t it, bit pinned, result_t beat);
		start <= 1'b1;
		item <= it;
		pin_valid <= pinned;
		pin_beat <= beat;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// random pause between beats: mostly short, a few long, some stretches with none
	task automatic pause_sender();
		int gap;
		if (burst_left == 0 && $urandom_range(0, 15) == 0)
			burst_left = $urandom_range(10, 30);
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if ($urandom_range(0, 9) < 4) begin
			gap = 0;
		end else if ($urandom_range(0, 9) < 9) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(10, 40);
		end
		if (gap != 0) begin
			start <= 1'b0;
			pin_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drain all expected beats and let the block go idle
	task automatic settle();
		start <= 1'b0;
		pin_valid <= 1'b0;
		@(posedge clk);
		while (due_beats.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_handlers(logic [MASK_W-1:0] m);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic item_t rand_raise();
		item_t it;
		it.kind = KIND_RAISE;
		it.event_code = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
		                                            : 8'($urandom_range(0, 19));
		it.event_context = $urandom;
		it.dispatch_count = 16'($urandom);
		return it;
	endfunction

	function automatic item_t rand_dispatch();
		item_t it;
		int    sel;
		it.kind = KIND_DISPATCH;
		it.event_code = 8'($urandom);
		it.event_context = $urandom;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			it.dispatch_count = 16'($urandom_range(0, 6));
		else if (sel < 9)
			it.dispatch_count = 16'($urandom_range(0, 40));
		else
			it.dispatch_count = 16'($urandom);
		return it;
	endfunction

	// random phase: fill bursts that overrun the ring, drain runs, and mixed traffic
	task automatic random_phase(int n_items);
		int sent;
		int mode;
		int runs;
		sent = 0;
		while (sent < n_items) begin
			mode = $urandom_range(0, 9);
			if (mode < 3) begin
				runs = $urandom_range(28, 36);
				repeat (runs) begin
					send_beat(rand_raise(), 1'b0, '0);
					pause_sender();
				end
				send_beat(rand_dispatch(), 1'b0, '0);
				pause_sender();
				sent += runs + 1;
			end else if (mode < 5) begin
				runs = $urandom_range(2, 6);
				repeat (runs) begin
					send_beat(rand_dispatch(), 1'b0, '0);
					pause_sender();
				end
				sent += runs;
			end else begin
				runs = $urandom_range(4, 12);
				repeat (runs) begin
					if ($urandom_range(0, 9) < 6)
						send_beat(rand_raise(), 1'b0, '0);
					else
						send_beat(rand_dispatch(), 1'b0, '0);
					pause_sender();
				end
				sent += runs;
			end
		end
	endtask

	// stimulus
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, handlers on codes zero and fifteen only
		set_handlers(16'h8001);
		foreach (dir_rows[i]) begin
			send_beat(dir_rows[i].it, dir_rows[i].pinned, dir_rows[i].beat);
			pause_sender();
		end

		// random traffic under several handler masks
		set_handlers(16'h0000);
		random_phase(RAND_ITEMS);
		set_handlers(16'hFFFF);
		random_phase(RAND_ITEMS);
		set_handlers(16'($urandom));
		random_phase(RAND_ITEMS);
		set_handlers(16'($urandom));
		random_phase(RAND_ITEMS);

		settle();
		if (due_beats.size() != 0) begin
			$error("%0d expected beats never arrived", due_beats.size());
			errs++;
		end
		if (errs == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: event_ring_queue_dispatcher.f
hw/rtl/erqd_pkg.sv
hw/rtl/erqd_ram.sv
hw/rtl/event_ring_queue_dispatcher.sv
hw/rtl/erqd_checker.sv
tb/tb.sv
